@@ hdl/flfd_pkg.sv @@
// ============================================================================
// flfd_pkg: shared definitions for the fixed-length frame deframer
// Register indexes, reset values and the time-message byte codes.
// ============================================================================
`default_nettype none

package flfd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINK_ENABLED  = 3'd0,
        CFG_START_BYTE    = 3'd1,
        CFG_END_BYTE      = 3'd2,
        CFG_LAST_FRAME_ID = 3'd3,
        CFG_FRAME_STRIDE  = 3'd4
    } cfg_reg_t;

    localparam logic       RST_LINK_ENABLED  = 1'b1;
    localparam logic [7:0] RST_START_BYTE    = 8'd170;
    localparam logic [7:0] RST_END_BYTE      = 8'd85;
    localparam logic [7:0] RST_LAST_FRAME_ID = 8'd119;
    localparam logic [7:0] RST_FRAME_STRIDE  = 8'd140;

    localparam logic [7:0] TIME_START = 8'h2A;
    localparam logic [7:0] TIME_END   = 8'h23;
    localparam int         TIME_LEN   = 6;
    localparam int         SLOT_W     = 3;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd5;

    // First position after the two start bytes.
    localparam int FIRST_POS = 2;
    // Position of the payload byte that carries the frame number.
    localparam int NUMBER_POS = 3;

endpackage

`default_nettype wire

@@ hdl/fixed_length_frame_deframer.sv @@
// ============================================================================
// fixed_length_frame_deframer
// Hunts for two start bytes, numbers the bytes of a fixed-length frame,
// emits payload, checks the footer and tracks a six-byte time message.
// ============================================================================
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------
//  input    | in_valid / in_ready       | rx_byte
//  output   | out_valid / out_ready     | payload_*, frame_*, crc, time_*
//  config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// One word is accepted per cycle; its result appears in the output register
// on the following cycle. The word is decoded in a single pass between the
// input handshake and that output register.
// While a result waits untaken, in_ready falls and the input stalls.
// Reset clears all frame and time state and loads the register defaults.
//
`default_nettype none

module fixed_length_frame_deframer #(
    parameter int PAYLOAD_END = 143
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [flfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [flfd_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic [7:0]       payload_index,
    output logic             in_frame,
    output logic             frame_done,
    output logic             frame_error,
    output logic [7:0]       frame_id,
    output logic [15:0]      frame_offset,
    output logic             last_frame,
    output logic [15:0]      crc_value,
    output logic             time_done,
    output logic [47:0]      time_bytes
);

    localparam int POS_W = $clog2(PAYLOAD_END + 5);
    localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(flfd_pkg::FIRST_POS);
    localparam logic [POS_W-1:0] POS_NUMBER = POS_W'(flfd_pkg::NUMBER_POS);
    localparam logic [POS_W-1:0] POS_PE     = POS_W'(PAYLOAD_END);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PAYLOAD_END + 1);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(PAYLOAD_END + 2);
    localparam logic [POS_W-1:0] POS_FOOT1  = POS_W'(PAYLOAD_END + 3);
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(PAYLOAD_END + 4);

    // Configuration registers
    logic       link_enabled_reg;
    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic [7:0] last_frame_id_reg;
    logic [7:0] frame_stride_reg;

    // Deframer state
    logic [15:0]      header_pair_reg,  header_pair_next;
    logic             frame_active_reg, frame_active_next;
    logic [POS_W-1:0] pos_reg,          pos_next;
    logic [15:0]      crc_hold_reg,     crc_hold_next;
    logic [7:0]       footer_first_reg, footer_first_next;
    logic [7:0]       number_hold_reg,  number_hold_next;
    logic [7:0]       time_ring_reg  [flfd_pkg::TIME_LEN];
    logic [7:0]       time_ring_next [flfd_pkg::TIME_LEN];
    logic [flfd_pkg::SLOT_W-1:0] time_slot_reg, time_slot_next;
    logic             time_active_reg,  time_active_next;

    // Result of the current word
    logic        pv, done, err, last, tdone;
    logic [7:0]  pb, pi, fnum;
    logic [15:0] foff;
    logic [47:0] ring_word;

    logic        out_valid_reg;
    logic        accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enabled_reg  <= flfd_pkg::RST_LINK_ENABLED;
            start_byte_reg    <= flfd_pkg::RST_START_BYTE;
            end_byte_reg      <= flfd_pkg::RST_END_BYTE;
            last_frame_id_reg <= flfd_pkg::RST_LAST_FRAME_ID;
            frame_stride_reg  <= flfd_pkg::RST_FRAME_STRIDE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                flfd_pkg::CFG_LINK_ENABLED:  link_enabled_reg  <= cfg_data[0];
                flfd_pkg::CFG_START_BYTE:    start_byte_reg    <= cfg_data;
                flfd_pkg::CFG_END_BYTE:      end_byte_reg      <= cfg_data;
                flfd_pkg::CFG_LAST_FRAME_ID: last_frame_id_reg <= cfg_data;
                flfd_pkg::CFG_FRAME_STRIDE:  frame_stride_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        header_pair_next  = header_pair_reg;
        frame_active_next = frame_active_reg;
        pos_next          = pos_reg;
        crc_hold_next     = crc_hold_reg;
        footer_first_next = footer_first_reg;
        number_hold_next  = number_hold_reg;
        time_ring_next    = time_ring_reg;
        time_slot_next    = time_slot_reg;
        time_active_next  = time_active_reg;
        pv    = 1'b0;
        pb    = 8'd0;
        pi    = 8'd0;
        done  = 1'b0;
        err   = 1'b0;
        fnum  = 8'd0;
        foff  = 16'd0;
        last  = 1'b0;
        tdone = 1'b0;

        if (link_enabled_reg)
        begin
            header_pair_next = {header_pair_reg[7:0], rx_byte};

            if (frame_active_reg)
            begin
                if (pos_reg == POS_NUMBER)
                begin
                    number_hold_next = rx_byte;
                end
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg <= POS_PE)
                begin
                    pv = 1'b1;
                    pb = rx_byte;
                    pi = 8'(pos_reg);
                end
                else if (pos_reg == POS_CRC_HI)
                begin
                    crc_hold_next[15:8] = rx_byte;
                end
                else if (pos_reg == POS_CRC_LO)
                begin
                    crc_hold_next[7:0] = rx_byte;
                end
                else if (pos_reg == POS_FOOT1)
                begin
                    footer_first_next = rx_byte;
                end
                else
                begin
                    // Second footer byte: the frame closes whatever it holds.
                    if (footer_first_reg == end_byte_reg && rx_byte == end_byte_reg)
                    begin
                        done = 1'b1;
                        fnum = number_hold_reg;
                        foff = 16'(number_hold_reg) * 16'(frame_stride_reg);
                        last = (number_hold_reg == last_frame_id_reg);
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                    frame_active_next = 1'b0;
                    footer_first_next = 8'd0;
                    pos_next          = '0;
                end
            end
            else if (header_pair_next == {start_byte_reg, start_byte_reg})
            begin
                frame_active_next = 1'b1;
                pos_next          = POS_FIRST;
                footer_first_next = 8'd0;
                header_pair_next  = 16'd0;
            end

            // While the link is enabled, the time ring sees every word, frame bytes included.
            if (rx_byte == flfd_pkg::TIME_START)
            begin
                for (int i = 0; i < flfd_pkg::TIME_LEN; i++)
                begin
                    time_ring_next[i] = 8'd0;
                end
                time_ring_next[0] = rx_byte;
                time_slot_next    = flfd_pkg::SLOT_W'(1);
                time_active_next  = 1'b1;
            end
            else
            begin
                time_ring_next[time_slot_reg] = rx_byte;
                time_slot_next = (time_slot_reg == flfd_pkg::SLOT_LAST) ?
                                 '0 : time_slot_reg + flfd_pkg::SLOT_W'(1);
                if (rx_byte == flfd_pkg::TIME_END && !frame_active_next && time_active_reg)
                begin
                    tdone            = 1'b1;
                    time_active_next = 1'b0;
                end
            end
        end

        for (int i = 0; i < flfd_pkg::TIME_LEN; i++)
        begin
            ring_word[8*i +: 8] = time_ring_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pair_reg  <= 16'd0;
            frame_active_reg <= 1'b0;
            pos_reg          <= '0;
            crc_hold_reg     <= 16'd0;
            footer_first_reg <= 8'd0;
            number_hold_reg  <= 8'd0;
            for (int i = 0; i < flfd_pkg::TIME_LEN; i++)
            begin
                time_ring_reg[i] <= 8'd0;
            end
            time_slot_reg    <= '0;
            time_active_reg  <= 1'b0;
        end
        else if (accept)
        begin
            header_pair_reg  <= header_pair_next;
            frame_active_reg <= frame_active_next;
            pos_reg          <= pos_next;
            crc_hold_reg     <= crc_hold_next;
            footer_first_reg <= footer_first_next;
            number_hold_reg  <= number_hold_next;
            time_ring_reg    <= time_ring_next;
            time_slot_reg    <= time_slot_next;
            time_active_reg  <= time_active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            payload_valid <= pv;
            payload_byte  <= pb;
            payload_index <= pi;
            in_frame      <= frame_active_next;
            frame_done    <= done;
            frame_error   <= err;
            frame_id      <= fnum;
            frame_offset  <= foff;
            last_frame    <= last;
            crc_value     <= crc_hold_next;
            time_done     <= tdone;
            time_bytes    <= ring_word;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_active_reg |-> (pos_reg >= POS_FIRST && pos_reg <= POS_MAX))
        else $error("frame position out of range");

    a_done_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(frame_done && frame_error))
        else $error("frame done and frame error together");

    a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && payload_valid) |-> in_frame)
        else $error("payload word outside a frame");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        time_slot_reg <= flfd_pkg::SLOT_LAST)
        else $error("time slot out of range");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word gave no result");
`endif

endmodule

`default_nettype wire

@@ verif/tb_fixed_length_frame_deframer.sv @@
// ============================================================================
// tb_fixed_length_frame_deframer
// Self-checking bench for the frame deframer. A byte stream is queued per
// phase (directed bytes, whole frames with random payload, time messages
// and noise) and fed through the input handshake. Every accepted byte is run
// through a local prediction of the deframer, and each output word is
// compared field by field with the oldest prediction. Phases change the
// register settings and the idling of both sides.
// ============================================================================

module tb_fixed_length_frame_deframer;

    localparam int FRAME_PAYLOAD_END = 143;
    localparam int QUIET_LIMIT       = 4000;
    localparam int SETTLE_CYCLES     = 4;

    typedef enum int {FOOTER_GOOD, FOOTER_BAD_FIRST, FOOTER_BAD_SECOND} footer_kind_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        in_frame;
        logic        frame_done;
        logic        frame_error;
        logic [7:0]  frame_id;
        logic [15:0] frame_offset;
        logic        last_frame;
        logic [15:0] crc_value;
        logic        time_done;
        logic [47:0] time_bytes;
    } deframe_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [flfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [flfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      rx_byte = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            payload_valid;
    logic [7:0]                      payload_byte;
    logic [7:0]                      payload_index;
    logic                            in_frame;
    logic                            frame_done;
    logic                            frame_error;
    logic [7:0]                      frame_id;
    logic [15:0]                     frame_offset;
    logic                            last_frame;
    logic [15:0]                     crc_value;
    logic                            time_done;
    logic [47:0]                     time_bytes;

    // Register copies.
    logic       link_on;
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] final_number;
    logic [7:0] stride;

    // Deframer state as predicted.
    logic [15:0] hunt_pair;
    logic        framing;
    logic [7:0]  frame_pos;
    logic [15:0] crc_word;
    logic [7:0]  footer_hold;
    logic [7:0]  number_byte;
    logic [7:0]  clock_ring [flfd_pkg::TIME_LEN];
    logic [2:0]  ring_slot;
    logic        clock_pending;

    logic [7:0]      rx_stream [$];
    deframe_result_t deframed_due [$];

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          fail_count = 0;
    int unsigned quiet_cycles = 0;

    fixed_length_frame_deframer #(
        .PAYLOAD_END (FRAME_PAYLOAD_END)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .in_frame      (in_frame),
        .frame_done    (frame_done),
        .frame_error   (frame_error),
        .frame_id      (frame_id),
        .frame_offset  (frame_offset),
        .last_frame    (last_frame),
        .crc_value     (crc_value),
        .time_done     (time_done),
        .time_bytes    (time_bytes)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic deframe_result_t deframe_byte(input logic [7:0] c);
        deframe_result_t r;
        logic [7:0]      p;
        r = '0;
        if (link_on)
        begin
            hunt_pair = {hunt_pair[7:0], c};
            if (framing)
            begin
                p = frame_pos;
                if (p == flfd_pkg::NUMBER_POS)
                    number_byte = c;
                if (p <= FRAME_PAYLOAD_END)
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    r.payload_index = p;
                end
                else if (p == FRAME_PAYLOAD_END + 1)
                    crc_word[15:8] = c;
                else if (p == FRAME_PAYLOAD_END + 2)
                    crc_word[7:0] = c;
                else if (p == FRAME_PAYLOAD_END + 3)
                    footer_hold = c;
                else
                begin
                    if (footer_hold == end_code && c == end_code)
                    begin
                        r.frame_done   = 1'b1;
                        r.frame_id     = number_byte;
                        r.frame_offset = 16'(number_byte) * 16'(stride);
                        r.last_frame   = (number_byte == final_number);
                    end
                    else
                        r.frame_error = 1'b1;
                    framing     = 1'b0;
                    footer_hold = '0;
                    frame_pos   = '0;
                end
                if (framing)
                    frame_pos = p + 8'd1;
            end
            else if (hunt_pair == {start_code, start_code})
            begin
                // The pair is consumed, so the next frame needs two fresh start bytes.
                framing     = 1'b1;
                frame_pos   = 8'(flfd_pkg::FIRST_POS);
                footer_hold = '0;
                hunt_pair   = '0;
            end

            if (c == flfd_pkg::TIME_START)
            begin
                for (int i = 0; i < flfd_pkg::TIME_LEN; i++)
                    clock_ring[i] = '0;
                ring_slot     = '0;
                clock_pending = 1'b1;
            end
            clock_ring[ring_slot] = c;
            ring_slot = (ring_slot == flfd_pkg::SLOT_LAST) ? 3'd0 : ring_slot + 3'd1;
            if (c == flfd_pkg::TIME_END && !framing && clock_pending)
            begin
                r.time_done   = 1'b1;
                clock_pending = 1'b0;
            end
        end
        r.in_frame  = framing;
        r.crc_value = crc_word;
        for (int i = 0; i < flfd_pkg::TIME_LEN; i++)
            r.time_bytes[8*i +: 8] = clock_ring[i];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic logic [7:0] pick_byte(input int bias_pct);
        if ($urandom_range(99) >= bias_pct)
            return 8'($urandom_range(255));
        case ($urandom_range(3))
            0:       return start_code;
            1:       return end_code;
            2:       return flfd_pkg::TIME_START;
            default: return flfd_pkg::TIME_END;
        endcase
    endfunction

    // Registers are only written while nothing is in flight.
    task automatic write_reg(input flfd_pkg::cfg_reg_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            flfd_pkg::CFG_LINK_ENABLED:  link_on      = val[0];
            flfd_pkg::CFG_START_BYTE:    start_code   = val;
            flfd_pkg::CFG_END_BYTE:      end_code     = val;
            flfd_pkg::CFG_LAST_FRAME_ID: final_number = val;
            flfd_pkg::CFG_FRAME_STRIDE:  stride       = val;
            default: ;
        endcase
    endtask

    task automatic add_frame(input logic [7:0] number, input footer_kind_t footer);
        logic [7:0] bad;
        // A guard byte keeps the header from pairing with whatever came before.
        rx_stream.push_back(~start_code);
        rx_stream.push_back(start_code);
        rx_stream.push_back(start_code);
        for (int pos = flfd_pkg::FIRST_POS; pos <= FRAME_PAYLOAD_END; pos++)
            rx_stream.push_back(pos == flfd_pkg::NUMBER_POS ? number : pick_byte(6));
        rx_stream.push_back(8'($urandom_range(255)));
        rx_stream.push_back(8'($urandom_range(255)));
        bad = end_code ^ (8'h01 << $urandom_range(7));
        rx_stream.push_back(footer == FOOTER_BAD_FIRST ? bad : end_code);
        rx_stream.push_back(footer == FOOTER_BAD_SECOND ? bad : end_code);
    endtask

    task automatic add_time_msg();
        int len;
        len = $urandom_range(8);
        rx_stream.push_back(flfd_pkg::TIME_START);
        repeat (len)
            rx_stream.push_back(8'($urandom_range(255)));
        rx_stream.push_back(flfd_pkg::TIME_END);
    endtask

    task automatic add_noise(input int count);
        repeat (count)
            rx_stream.push_back(pick_byte(30));
    endtask

    task automatic drain();
        @(negedge clk);
        while (rx_stream.size() != 0 || in_valid || deframed_due.size() != 0)
            @(negedge clk);
    endtask

    // Sender: a word is held until taken, then the next one may follow.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframed_due.push_back(deframe_byte(rx_byte));
            if (!in_valid || in_ready)
            begin
                if (rx_stream.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_stream.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        deframe_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (deframed_due.size() == 0)
                report_mismatch("output word with no prediction waiting");
            else
            begin
                want = deframed_due.pop_front();
                check_field("payload_valid", payload_valid, want.payload_valid);
                check_field("payload_byte", payload_byte, want.payload_byte);
                check_field("payload_index", payload_index, want.payload_index);
                check_field("in_frame", in_frame, want.in_frame);
                check_field("frame_done", frame_done, want.frame_done);
                check_field("frame_error", frame_error, want.frame_error);
                check_field("frame_id", frame_id, want.frame_id);
                check_field("frame_offset", frame_offset, want.frame_offset);
                check_field("last_frame", last_frame, want.last_frame);
                check_field("crc_value", crc_value, want.crc_value);
                check_field("time_done", time_done, want.time_done);
                check_field("time_bytes", time_bytes, want.time_bytes);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        link_on       = flfd_pkg::RST_LINK_ENABLED;
        start_code    = flfd_pkg::RST_START_BYTE;
        end_code      = flfd_pkg::RST_END_BYTE;
        final_number  = flfd_pkg::RST_LAST_FRAME_ID;
        stride        = flfd_pkg::RST_FRAME_STRIDE;
        hunt_pair     = '0;
        framing       = 1'b0;
        frame_pos     = '0;
        crc_word      = '0;
        footer_hold   = '0;
        number_byte   = '0;
        ring_slot     = '0;
        clock_pending = 1'b0;
        for (int i = 0; i < flfd_pkg::TIME_LEN; i++)
            clock_ring[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, no idling: field extremes, time messages, near-miss headers,
        // and a frame whose second footer byte is wrong.
        idle_pct  = 0;
        stall_pct = 0;
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(flfd_pkg::TIME_END);
        rx_stream.push_back(flfd_pkg::TIME_START);
        for (int i = 0; i < 7; i++)
            rx_stream.push_back(8'h31 + 8'(i));
        rx_stream.push_back(flfd_pkg::TIME_END);
        rx_stream.push_back(flfd_pkg::TIME_START);
        rx_stream.push_back(flfd_pkg::TIME_END);
        rx_stream.push_back(flfd_pkg::TIME_END);
        rx_stream.push_back(flfd_pkg::RST_START_BYTE);
        rx_stream.push_back(flfd_pkg::RST_END_BYTE);
        rx_stream.push_back(flfd_pkg::RST_START_BYTE);
        rx_stream.push_back(8'h00);
        add_frame(final_number, FOOTER_BAD_SECOND);
        rx_stream.push_back(flfd_pkg::TIME_END);
        add_noise(12);
        drain();

        // Link off: bits above bit 0 of the written word must be dropped.
        write_reg(flfd_pkg::CFG_LINK_ENABLED, 8'hFE);
        repeat (3)
        begin
            rx_stream.push_back(start_code);
            rx_stream.push_back(start_code);
            rx_stream.push_back(flfd_pkg::TIME_START);
            rx_stream.push_back(flfd_pkg::TIME_END);
            rx_stream.push_back(8'($urandom_range(255)));
        end
        drain();
        write_reg(flfd_pkg::CFG_LINK_ENABLED, 8'h01);

        // Low extremes for the header, high for the footer and the offset; idle sender.
        write_reg(flfd_pkg::CFG_START_BYTE, 8'h00);
        write_reg(flfd_pkg::CFG_END_BYTE, 8'hFF);
        write_reg(flfd_pkg::CFG_LAST_FRAME_ID, 8'hFF);
        write_reg(flfd_pkg::CFG_FRAME_STRIDE, 8'hFF);
        idle_pct  = 86;
        stall_pct = 0;
        add_time_msg();
        add_frame(8'hFF, FOOTER_GOOD);
        drain();
        add_time_msg();
        add_noise(10);
        drain();

        // Opposite extremes, stalling receiver, first footer byte wrong.
        write_reg(flfd_pkg::CFG_START_BYTE, 8'hFF);
        write_reg(flfd_pkg::CFG_END_BYTE, 8'h00);
        write_reg(flfd_pkg::CFG_LAST_FRAME_ID, 8'hFF);
        write_reg(flfd_pkg::CFG_FRAME_STRIDE, 8'h00);
        idle_pct  = 0;
        stall_pct = 86;
        add_frame(8'hFF, FOOTER_BAD_FIRST);
        add_noise(10);
        drain();

        // Header and footer share codes with the time message.
        write_reg(flfd_pkg::CFG_START_BYTE, flfd_pkg::TIME_START);
        write_reg(flfd_pkg::CFG_END_BYTE, flfd_pkg::TIME_END);
        write_reg(flfd_pkg::CFG_LAST_FRAME_ID, 8'($urandom_range(255)));
        write_reg(flfd_pkg::CFG_FRAME_STRIDE, 8'($urandom_range(255)));
        idle_pct  = 9;
        stall_pct = 9;
        add_time_msg();
        add_noise(20);
        add_time_msg();
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
